// ----- design/bggc_pkg.sv -----
// Package: constants, codes and pipeline types of the bilinear grid ground classifier.
`timescale 1ns / 1ps
package bggc_pkg;

   localparam int GRID_COLS = 128;
   localparam int GRID_ROWS = 128;
   localparam int FRAC_BITS = 16;
   localparam int COL_BITS  = $clog2(GRID_COLS);
   localparam int ROW_BITS  = $clog2(GRID_ROWS);
   localparam int QBITS     = COL_BITS + FRAC_BITS;
   localparam int STEP_W    = 31;
   localparam int REM_W     = STEP_W + QBITS + 1;
   localparam int ADDR_W    = COL_BITS + ROW_BITS - 2;
   localparam int BANK_DEPTH = (GRID_COLS / 2) * (GRID_ROWS / 2);
   localparam int DIV_LAST  = QBITS + 1;
   localparam int WGT_W     = FRAC_BITS + 2;
   localparam int PROD_W    = 32 + WGT_W;
   localparam int TOP_W     = 33;
   localparam int PROD2_W   = TOP_W + WGT_W;
   localparam int DIFF_W    = 34;

   typedef enum logic {
      OP_LOAD     = 1'b0,
      OP_CLASSIFY = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      REG_ORIGIN_X   = 3'd0,
      REG_ORIGIN_Z   = 3'd1,
      REG_STEP_X     = 3'd2,
      REG_STEP_Z     = 3'd3,
      REG_THRESHOLD  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic                valid;
      opcode_type          opcode;
      logic [COL_BITS-1:0] node_col;
      logic [ROW_BITS-1:0] node_row;
      logic [31:0]         node_height;
      logic [31:0]         point_height;
      logic [REM_W-1:0]    rem_x;
      logic [QBITS-1:0]    q_x;
      logic                out_x;
      logic [REM_W-1:0]    rem_z;
      logic [QBITS-1:0]    q_z;
      logic                out_z;
   } div_type;

   typedef struct packed {
      logic        valid;
      opcode_type  opcode;
      logic        out;
      logic [31:0] point_height;
   } tail_type;

endpackage

// ----- design/bilinear_grid_ground_classifier_top.sv -----
// Top level: pipelined grid locate, banked height read, bilinear blend and threshold test.
//
//  channel | ports   | direction | content
//  --------+---------+-----------+--------------------------------------------
//  request | req_*   | in        | node load or point to classify
//  result  | rsp_*   | out       | ground flag, out-of-grid flag, difference
//  config  | csr_*   | in/out    | origin, cell steps, ground threshold
//
// One item per cycle unless a stalled result holds the pipeline.
// The depth is set by the cell divide: one quotient bit per stage, 23 stages.
// Loads write the grid in the read stage, so they order with points exactly.
// A stalled result stalls the whole pipeline; nothing is dropped or repeated.
// Reset clears valid bits and registers only; the grid holds no reset value.
`timescale 1ns / 1ps
module bilinear_grid_ground_classifier_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // node_col[6:0], node_row[13:7], node_height[45:14], point_x[77:46],
   // point_height[109:78], point_z[141:110], zero fill
   input  logic [143:0] req_tdata,
   // opcode
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // is_ground[0], height_difference[33:1], zero fill
   output logic [39:0] rsp_tdata,
   // out_of_grid
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bggc_pkg::*;

   logic [31:0]       origin_x_ff, origin_z_ff;
   logic [STEP_W-1:0] step_x_ff, step_z_ff, threshold_ff;
   logic              advance;

   div_type pipe_ff [0:DIV_LAST];
   div_type pipe_in [0:DIV_LAST];

   tail_type              a_ff, r_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic                  a_col0_ff, a_row0_ff, r_col0_ff, r_row0_ff;
   logic [FRAC_BITS-1:0]  a_fx_ff, a_fz_ff, r_fx_ff, r_fz_ff;
   logic [FRAC_BITS-1:0]  m1_fz_ff, m2_fz_ff;
   logic [ADDR_W-1:0]     a_addr_ff [0:3];
   logic [ADDR_W-1:0]     a_waddr_ff;
   logic [1:0]            a_wbank_ff;
   logic [31:0]           a_wdata_ff;
   logic signed [31:0]    rd_ff [0:3];
   logic signed [PROD_W-1:0]  p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [TOP_W-1:0]   top_ff, bot_ff;
   logic signed [PROD2_W-1:0] q0_ff, q1_ff;
   logic signed [DIFF_W-1:0]  surf_ff, diff_ff;
   logic                  rsp_tvalid_ff, is_ground_ff, oog_ff;
   logic [32:0]           hdiff_ff;

   logic signed [32:0]    dx, dz;
   logic [COL_BITS-1:0]   last_col;
   logic [ROW_BITS-1:0]   last_row;
   logic                  last_out;
   logic [ADDR_W-1:0]     addr_in [0:3];
   logic signed [31:0]    h00, h10, h01, h11;
   logic signed [WGT_W-1:0] wx1, wx0, wz1, wz0;
   logic signed [PROD_W:0]  sum_top, sum_bot;
   logic signed [PROD2_W:0] sum_surf;
   logic signed [DIFF_W-1:0] mag;
   logic signed [DIFF_W-1:0] half_d;

   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_z_ff  <= '0;
         step_x_ff    <= STEP_W'(65536);
         step_z_ff    <= STEP_W'(65536);
         threshold_ff <= STEP_W'(32768);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_paddr[4:2])
            REG_ORIGIN_X:  origin_x_ff  <= csr_pwdata;
            REG_ORIGIN_Z:  origin_z_ff  <= csr_pwdata;
            REG_STEP_X:    step_x_ff    <= csr_pwdata[STEP_W-1:0];
            REG_STEP_Z:    step_z_ff    <= csr_pwdata[STEP_W-1:0];
            REG_THRESHOLD: threshold_ff <= csr_pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_ORIGIN_X:  csr_prdata = origin_x_ff;
         REG_ORIGIN_Z:  csr_prdata = origin_z_ff;
         REG_STEP_X:    csr_prdata = {1'b0, step_x_ff};
         REG_STEP_Z:    csr_prdata = {1'b0, step_z_ff};
         REG_THRESHOLD: csr_prdata = {1'b0, threshold_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // locate: subtract origin, then long divide (dx << FRAC_BITS) by the step
   always_comb begin
      dx = $signed({req_tdata[77], req_tdata[77:46]}) - $signed({origin_x_ff[31], origin_x_ff});
      dz = $signed({req_tdata[141], req_tdata[141:110]})
         - $signed({origin_z_ff[31], origin_z_ff});
      pipe_in[0].valid        = req_tvalid;
      pipe_in[0].opcode       = opcode_type'(req_tuser);
      pipe_in[0].node_col     = req_tdata[6:0];
      pipe_in[0].node_row     = req_tdata[13:7];
      pipe_in[0].node_height  = req_tdata[45:14];
      pipe_in[0].point_height = req_tdata[109:78];
      pipe_in[0].rem_x        = REM_W'({dx[31:0], {FRAC_BITS{1'b0}}});
      pipe_in[0].q_x          = '0;
      pipe_in[0].out_x        = dx[32];
      pipe_in[0].rem_z        = REM_W'({dz[31:0], {FRAC_BITS{1'b0}}});
      pipe_in[0].q_z          = '0;
      pipe_in[0].out_z        = dz[32];

      pipe_in[1] = pipe_ff[0];
      pipe_in[1].out_x = pipe_ff[0].out_x || (step_x_ff == '0)
         || (pipe_ff[0].rem_x >= (REM_W'(step_x_ff) << QBITS));
      pipe_in[1].out_z = pipe_ff[0].out_z || (step_z_ff == '0)
         || (pipe_ff[0].rem_z >= (REM_W'(step_z_ff) << QBITS));

      for (int s = 0; s < QBITS; s++) begin
         pipe_in[s+2] = pipe_ff[s+1];
         if (pipe_ff[s+1].rem_x >= (REM_W'(step_x_ff) << (QBITS-1-s))) begin
            pipe_in[s+2].rem_x = pipe_ff[s+1].rem_x - (REM_W'(step_x_ff) << (QBITS-1-s));
            pipe_in[s+2].q_x[QBITS-1-s] = 1'b1;
         end
         if (pipe_ff[s+1].rem_z >= (REM_W'(step_z_ff) << (QBITS-1-s))) begin
            pipe_in[s+2].rem_z = pipe_ff[s+1].rem_z - (REM_W'(step_z_ff) << (QBITS-1-s));
            pipe_in[s+2].q_z[QBITS-1-s] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_LAST; i++) begin
            pipe_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         for (int i = 0; i <= DIV_LAST; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   // bank select: bank {row[0], col[0]} holds the node at {row >> 1, col >> 1}
   always_comb begin
      last_col = pipe_ff[DIV_LAST].q_x[QBITS-1:FRAC_BITS];
      last_row = pipe_ff[DIV_LAST].q_z[QBITS-1:FRAC_BITS];
      last_out = pipe_ff[DIV_LAST].out_x || pipe_ff[DIV_LAST].out_z
         || (last_col > COL_BITS'(GRID_COLS-2)) || (last_row > ROW_BITS'(GRID_ROWS-2));
      for (int b = 0; b < 4; b++) begin
         logic [COL_BITS-1:0] csel;
         logic [ROW_BITS-1:0] rsel;
         csel = last_col + COL_BITS'(b[0] != last_col[0]);
         rsel = last_row + ROW_BITS'(b[1] != last_row[0]);
         addr_in[b] = {rsel[ROW_BITS-1:1], csel[COL_BITS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
      end else if (advance) begin
         a_ff.valid        <= pipe_ff[DIV_LAST].valid;
         a_ff.opcode       <= pipe_ff[DIV_LAST].opcode;
         a_ff.out          <= last_out;
         a_ff.point_height <= pipe_ff[DIV_LAST].point_height;
         a_col0_ff  <= last_col[0];
         a_row0_ff  <= last_row[0];
         a_fx_ff    <= pipe_ff[DIV_LAST].q_x[FRAC_BITS-1:0];
         a_fz_ff    <= pipe_ff[DIV_LAST].q_z[FRAC_BITS-1:0];
         for (int b = 0; b < 4; b++) begin
            a_addr_ff[b] <= addr_in[b];
         end
         a_waddr_ff <= {pipe_ff[DIV_LAST].node_row[ROW_BITS-1:1],
                        pipe_ff[DIV_LAST].node_col[COL_BITS-1:1]};
         a_wbank_ff <= {pipe_ff[DIV_LAST].node_row[0], pipe_ff[DIV_LAST].node_col[0]};
         a_wdata_ff <= pipe_ff[DIV_LAST].node_height;
      end
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [31:0] mem [0:BANK_DEPTH-1];
      always_ff @(posedge clock) begin
         if (advance && a_ff.valid) begin
            if (a_ff.opcode == OP_LOAD && a_wbank_ff == 2'(b)) begin
               mem[a_waddr_ff] <= a_wdata_ff;
            end
            rd_ff[b] <= $signed(mem[a_addr_ff[b]]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff.valid  <= 1'b0;
         m1_ff.valid <= 1'b0;
         m2_ff.valid <= 1'b0;
         m3_ff.valid <= 1'b0;
         m4_ff.valid <= 1'b0;
         m5_ff.valid <= 1'b0;
      end else if (advance) begin
         r_ff  <= a_ff;
         m1_ff <= r_ff;
         m2_ff <= m1_ff;
         m3_ff <= m2_ff;
         m4_ff <= m3_ff;
         m5_ff <= m4_ff;
      end
   end

   always_comb begin
      h00 = rd_ff[{r_row0_ff, r_col0_ff}];
      h10 = rd_ff[{r_row0_ff, !r_col0_ff}];
      h01 = rd_ff[{!r_row0_ff, r_col0_ff}];
      h11 = rd_ff[{!r_row0_ff, !r_col0_ff}];
      wx1 = $signed({2'b00, r_fx_ff});
      wx0 = $signed(WGT_W'(1 << FRAC_BITS)) - wx1;
      wz1 = $signed({2'b00, m2_fz_ff});
      wz0 = $signed(WGT_W'(1 << FRAC_BITS)) - wz1;
      sum_top  = (PROD_W+1)'(p0_ff) + (PROD_W+1)'(p1_ff)
               + $signed((PROD_W+1)'(1 << (FRAC_BITS-1)));
      sum_bot  = (PROD_W+1)'(p2_ff) + (PROD_W+1)'(p3_ff)
               + $signed((PROD_W+1)'(1 << (FRAC_BITS-1)));
      sum_surf = (PROD2_W+1)'(q0_ff) + (PROD2_W+1)'(q1_ff)
               + $signed((PROD2_W+1)'(1 << (FRAC_BITS-1)));
      half_d   = '0;
      mag = diff_ff[DIFF_W-1] ? (half_d - diff_ff) : diff_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_col0_ff <= a_col0_ff;
         r_row0_ff <= a_row0_ff;
         r_fx_ff   <= a_fx_ff;
         r_fz_ff   <= a_fz_ff;
         m1_fz_ff  <= r_fz_ff;
         m2_fz_ff  <= m1_fz_ff;
         p0_ff   <= h00 * wx0;
         p1_ff   <= h10 * wx1;
         p2_ff   <= h01 * wx0;
         p3_ff   <= h11 * wx1;
         top_ff  <= TOP_W'(sum_top >>> FRAC_BITS);
         bot_ff  <= TOP_W'(sum_bot >>> FRAC_BITS);
         q0_ff   <= top_ff * wz0;
         q1_ff   <= bot_ff * wz1;
         surf_ff <= DIFF_W'(sum_surf >>> FRAC_BITS);
         diff_ff <= surf_ff - $signed({{(DIFF_W-32){m4_ff.point_height[31]}},
                                       m4_ff.point_height});
         is_ground_ff <= !m5_ff.out && (mag < $signed({3'b000, threshold_ff}));
         oog_ff       <= m5_ff.out;
         hdiff_ff     <= m5_ff.out ? 33'd0 : diff_ff[32:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= m5_ff.valid && (m5_ff.opcode == OP_CLASSIFY);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'b000000, hdiff_ff, is_ground_ff};
   assign rsp_tuser  = oog_ff;

endmodule

// ----- design/bggc_checker.sv -----
// Checker: port-level properties of the classifier, bound to the top level.
`timescale 1ns / 1ps
module bggc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser
);
   a_oog_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[33:0] == 34'd0))
      else $error("out-of-grid result carries data");

   a_ground_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> !rsp_tuser)
      else $error("ground flag on out-of-grid result");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty result register");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");
endmodule

bind bilinear_grid_ground_classifier_top bggc_checker u_bggc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
